>>> rtl/asu_pkg.sv
package asu_pkg;

    // Operation codes carried in the input tuser field
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_DISARM   = 2'd1;
    localparam logic [1:0] OP_OVERRIDE = 2'd2;

    // Arm direction codes
    localparam logic [2:0] DIR_NONE      = 3'd0;
    localparam logic [2:0] DIR_PITCH_MIN = 3'd1;
    localparam logic [2:0] DIR_PITCH_MAX = 3'd2;
    localparam logic [2:0] DIR_ROLL_MIN  = 3'd3;
    localparam logic [2:0] DIR_ROLL_MAX  = 3'd4;
    localparam logic [2:0] DIR_YAW_MIN   = 3'd5;
    localparam logic [2:0] DIR_YAW_MAX   = 3'd6;
    localparam logic [2:0] DIR_SWITCH    = 3'd7;

    // Stick region codes
    localparam logic [1:0] REGION_NONE   = 2'd0;
    localparam logic [1:0] REGION_ARM    = 2'd1;
    localparam logic [1:0] REGION_DISARM = 2'd2;
    localparam logic [1:0] REGION_SWITCH = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_THROTTLE_LOW     = 2'd0;
    localparam logic [1:0] CFG_ARM_DIRECTION    = 2'd1;
    localparam logic [1:0] CFG_ARM_HOLD_TIME    = 2'd2;
    localparam logic [1:0] CFG_ZERO_THR_TIMEOUT = 2'd3;

    localparam logic [31:0] DISARM_KEY     = 32'hDEADBEEF;
    localparam logic [15:0] HOLD_RESET     = 16'd10;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd30;
    localparam logic [19:0] ARM_SCALE      = 20'd10;
    localparam logic signed [17:0] LVL_ONE = 18'sd16384;

    typedef struct packed {
        logic [14:0] throttle_low_lvl;
        logic [2:0]  arm_direction;
        logic [15:0] arm_hold_time;
        logic [15:0] zero_throttle_timeout;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         operation;
        logic               rc_connected;
        logic               host_ctrl;
        logic [14:0]        throttle_level;
        logic signed [15:0] pitch_level;
        logic signed [15:0] roll_level;
        logic signed [15:0] yaw_level;
        logic               switch_top;
        logic [31:0]        disarm_key;
        logic               override_length_ok;
        logic               override_in_range;
    } t_item;

    typedef struct packed {
        logic [1:0] region;
        logic       low_thr;
    } t_region_info;

    typedef struct packed {
        logic       armed;
        logic       override_on;
        logic [1:0] stick_region;
    } t_result;

endpackage

>>> rtl/asu_region.sv
module asu_region
    import asu_pkg::*;
(
    input  t_cfg         i_cfg,
    input  t_item        i_item,
    output t_region_info o_info
);

    logic signed [17:0] lvl;
    logic signed [17:0] end_thr;
    logic               low_thr;
    logic               at_max;
    logic               at_min;
    logic               min_dir;

    // Pick the stick that the arm direction watches
    always_comb begin
        case (i_cfg.arm_direction) inside
            DIR_PITCH_MIN, DIR_PITCH_MAX: lvl = 18'(i_item.pitch_level);
            DIR_ROLL_MIN, DIR_ROLL_MAX:   lvl = 18'(i_item.roll_level);
            default:                      lvl = 18'(i_item.yaw_level);
        endcase
    end

    // End threshold is one minus twice the throttle threshold
    assign end_thr = LVL_ONE - $signed({2'b00, i_cfg.throttle_low_lvl, 1'b0});
    assign at_max  = lvl >= end_thr;
    assign at_min  = lvl <= -end_thr;
    assign low_thr = {1'b0, i_item.throttle_level} <= {1'b0, i_cfg.throttle_low_lvl};
    assign min_dir = (i_cfg.arm_direction == DIR_PITCH_MIN) ||
                     (i_cfg.arm_direction == DIR_ROLL_MIN) ||
                     (i_cfg.arm_direction == DIR_YAW_MIN);

    // Classify the stick position
    always_comb begin
        o_info.low_thr = low_thr;
        if (i_cfg.arm_direction == DIR_SWITCH) begin
            o_info.region = i_item.switch_top ? REGION_SWITCH : REGION_NONE;
        end else if (!low_thr || i_cfg.arm_direction == DIR_NONE) begin
            o_info.region = REGION_NONE;
        end else if (min_dir) begin
            o_info.region = at_min ? REGION_ARM : (at_max ? REGION_DISARM : REGION_NONE);
        end else begin
            o_info.region = at_max ? REGION_ARM : (at_min ? REGION_DISARM : REGION_NONE);
        end
    end

endmodule

>>> rtl/asu_step.sv
module asu_step
    import asu_pkg::*;
#(
    parameter int TICK_RATE = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_result
);

    // Counters are kept as quotient and remainder by the tick rate
    localparam int RW = (TICK_RATE > 1) ? $clog2(TICK_RATE) : 1;
    localparam logic [15:0]   SAT_Q     = 16'(65535 / TICK_RATE);
    localparam logic [RW-1:0] SAT_R     = RW'(65535 % TICK_RATE);
    localparam logic [RW-1:0] R_LAST    = RW'(TICK_RATE - 1);
    localparam logic [15:0]   OVR_LIMIT = 16'(TICK_RATE / 2);

    typedef struct packed {
        logic [15:0]   q;
        logic [RW-1:0] r;
    } t_tcnt;

    function automatic t_tcnt cnt_inc(input t_tcnt c);
        t_tcnt v;
        v = c;
        if (!(c.q == SAT_Q && c.r == SAT_R)) begin
            if (c.r == R_LAST) begin
                v.q = c.q + 16'd1;
                v.r = '0;
            end else begin
                v.r = c.r + RW'(1);
            end
        end
        return v;
    endfunction

    logic        r_armed, n_armed;
    logic        r_pend, n_pend;
    logic        r_latch, n_latch;
    t_tcnt       r_arm, n_arm;
    t_tcnt       r_dis, n_dis;
    t_tcnt       r_idle, n_idle;
    logic        r_ov, n_ov;
    logic [15:0] r_ovc, n_ovc;
    logic [1:0]  region;

    t_region_info info;

    asu_region u_region (
        .i_cfg  (i_cfg),
        .i_item (i_item),
        .o_info (info)
    );

    // Next state for one item
    always_comb begin
        n_armed = r_armed;
        n_pend  = r_pend;
        n_latch = r_latch;
        n_arm   = r_arm;
        n_dis   = r_dis;
        n_idle  = r_idle;
        n_ov    = r_ov;
        n_ovc   = r_ovc;
        region  = REGION_NONE;
        case (i_item.operation)
            OP_TICK: begin
                if (!r_ov) begin
                    if (n_pend) begin
                        // Forced disarm: drop everything
                        n_armed = 1'b0;
                        n_pend  = 1'b0;
                        n_latch = 1'b0;
                        n_arm   = '0;
                        n_dis   = '0;
                        n_idle  = '0;
                    end else if (!i_item.rc_connected || i_cfg.arm_direction == DIR_NONE) begin
                        n_armed = 1'b0;
                    end else begin
                        region = info.region;
                        if (n_armed && i_item.host_ctrl) begin
                            n_idle = '0;
                        end
                        if (i_cfg.arm_direction == DIR_SWITCH) begin
                            if (region == REGION_SWITCH) begin
                                if (!n_armed && n_latch && info.low_thr) begin
                                    if (20'(n_arm.q) * ARM_SCALE >= 20'(i_cfg.arm_hold_time)) begin
                                        n_armed = 1'b1;
                                        n_latch = 1'b0;
                                    end else begin
                                        n_arm  = cnt_inc(n_arm);
                                        n_idle = '0;
                                    end
                                end else if (n_armed && n_latch) begin
                                    n_latch = 1'b0;
                                    n_armed = 1'b0;
                                    n_arm   = '0;
                                    n_idle  = '0;
                                end
                            end else begin
                                n_arm   = '0;
                                n_idle  = cnt_inc(n_idle);
                                n_latch = 1'b1;
                            end
                        end else if (region == REGION_ARM) begin
                            if (20'(n_arm.q) * ARM_SCALE >= 20'(i_cfg.arm_hold_time)) begin
                                n_armed = 1'b1;
                            end else begin
                                n_arm  = cnt_inc(n_arm);
                                n_dis  = '0;
                                n_idle = '0;
                            end
                        end else if (region == REGION_DISARM) begin
                            if (n_dis.q >= i_cfg.arm_hold_time) begin
                                n_armed = 1'b0;
                            end else begin
                                n_dis  = cnt_inc(n_dis);
                                n_arm  = '0;
                                n_idle = '0;
                            end
                        end else begin
                            n_arm = '0;
                            n_dis = '0;
                        end

                        // Zero-throttle timeout reads the idle count as updated above
                        if (i_cfg.zero_throttle_timeout != '0 && n_armed) begin
                            if (info.low_thr) begin
                                if (n_idle.q > i_cfg.zero_throttle_timeout) begin
                                    n_armed = 1'b0;
                                end else begin
                                    n_idle = cnt_inc(n_idle);
                                    n_arm  = '0;
                                    n_dis  = '0;
                                end
                            end else begin
                                n_idle = '0;
                            end
                        end
                    end
                end
                // Override lapse check
                if (n_pend) begin
                    n_ov = 1'b0;
                end else if (n_ov && n_ovc > OVR_LIMIT) begin
                    n_ov = 1'b0;
                end else if (n_ovc != 16'hFFFF) begin
                    n_ovc = n_ovc + 16'd1;
                end
            end
            OP_DISARM: begin
                if (i_item.disarm_key == DISARM_KEY) begin
                    n_pend = 1'b1;
                end
            end
            OP_OVERRIDE: begin
                if (i_item.override_length_ok) begin
                    if (i_item.override_in_range) begin
                        n_ovc = '0;
                        n_ov  = 1'b1;
                    end else begin
                        n_ov = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.armed        = n_armed | n_ov;
    assign o_result.override_on  = n_ov;
    assign o_result.stick_region = region;

    // Hold supervisor state, advance once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_pend  <= 1'b0;
            r_latch <= 1'b0;
            r_arm   <= '0;
            r_dis   <= '0;
            r_idle  <= '0;
            r_ov    <= 1'b0;
            r_ovc   <= '0;
        end else if (i_en) begin
            r_armed <= n_armed;
            r_pend  <= n_pend;
            r_latch <= n_latch;
            r_arm   <= n_arm;
            r_dis   <= n_dis;
            r_idle  <= n_idle;
            r_ov    <= n_ov;
            r_ovc   <= n_ovc;
        end
    end

endmodule

>>> rtl/arming_supervisor_unit.sv
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: operation; tdata: item fields
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: armed, override_on, stick_region
// cfg       in   i_cfg_we (no wait)            i_cfg_addr selects register, i_cfg_data
//
// One item per cycle while m_axis_tready does not stall; each accepted item yields one result.
// Path: input register, next-state logic with state update, result register.
// Reset is synchronous, active low; it clears state and loads register defaults.
// When the result register is held by m_axis_tready low, the input register still
// takes one more item; s_axis_tready drops only when both registers are full.
module arming_supervisor_unit
    import asu_pkg::*;
#(
    parameter int TICK_RATE = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] rc_connected, [1] host_ctrl, [16:2] throttle_level,
    // [32:17] pitch_level, [48:33] roll_level, [64:49] yaw_level, [65] switch_top,
    // [97:66] disarm_key, [98] override_length_ok, [99] override_in_range, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] armed, [1] override_on, [3:2] stick_region, [7:4] zero
    output logic [7:0]   m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result step_result;
    logic    advance;
    logic    in_fire;
    logic    step_en;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign step_en       = r_in_valid && advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.throttle_low_lvl      <= '0;
            r_cfg.arm_direction         <= DIR_NONE;
            r_cfg.arm_hold_time         <= HOLD_RESET;
            r_cfg.zero_throttle_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_THROTTLE_LOW:     r_cfg.throttle_low_lvl      <= i_cfg_data[14:0];
                CFG_ARM_DIRECTION:    r_cfg.arm_direction         <= i_cfg_data[2:0];
                CFG_ARM_HOLD_TIME:    r_cfg.arm_hold_time         <= i_cfg_data;
                CFG_ZERO_THR_TIMEOUT: r_cfg.zero_throttle_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.operation          <= s_axis_tuser;
            r_in.rc_connected       <= s_axis_tdata[0];
            r_in.host_ctrl          <= s_axis_tdata[1];
            r_in.throttle_level     <= s_axis_tdata[16:2];
            r_in.pitch_level        <= s_axis_tdata[32:17];
            r_in.roll_level         <= s_axis_tdata[48:33];
            r_in.yaw_level          <= s_axis_tdata[64:49];
            r_in.switch_top         <= s_axis_tdata[65];
            r_in.disarm_key         <= s_axis_tdata[97:66];
            r_in.override_length_ok <= s_axis_tdata[98];
            r_in.override_in_range  <= s_axis_tdata[99];
        end
    end

    asu_step #(
        .TICK_RATE (TICK_RATE)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.stick_region, r_out.override_on, r_out.armed};

`ifndef SYNTH
    // An active override always reports as armed
    a_override_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
        else $error("override active without armed");

    // A stick region is only reported by a tick that ran the arming check
    a_region_no_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3:2] != REGION_NONE) |-> !m_axis_tdata[1])
        else $error("region reported while override active");

    // Input backpressure only when both registers hold items and the output stalls
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

>>> dv/arming_supervisor_unit_tb.sv
module arming_supervisor_unit_tb;
    import asu_pkg::*;

    localparam int TICKS_PER_SEC = 20;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [0] rc_connected, [1] host_ctrl, [16:2] throttle_level,
    // [32:17] pitch_level, [48:33] roll_level, [64:49] yaw_level, [65] switch_top,
    // [97:66] disarm_key, [98] override_length_ok, [99] override_in_range, [103:100] zero
    logic [103:0] s_axis_tdata = '0;
    // [1:0] operation
    logic [1:0]   s_axis_tuser = OP_TICK;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] armed, [1] override_on, [3:2] stick_region, [7:4] zero
    logic [7:0]   m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = CFG_THROTTLE_LOW;
    logic [15:0]  i_cfg_data = '0;

    arming_supervisor_unit #(
        .TICK_RATE(TICKS_PER_SEC)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 time unit clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_item   pending_items[$];
    t_result expected_status[$];
    t_item   driven_item;
    logic    item_taken = 1'b0;
    logic    rst_done = 1'b0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      mismatches = 0;

    // Shadow copy of the supervisor registers and state
    t_cfg        shadow_cfg;
    logic        is_armed = 1'b0;
    logic        kill_pending = 1'b0;
    logic        switch_released = 1'b0;
    logic [15:0] arm_ticks = '0;
    logic [15:0] disarm_ticks = '0;
    logic [15:0] idle_ticks = '0;
    logic        ovr_active = 1'b0;
    logic [15:0] ovr_ticks = '0;

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Advance the shadow supervisor by one item and return its status
    function automatic t_result step_supervisor(t_item it);
        t_result res;
        logic    low_thr;
        logic    arm_due;
        int      lvl;
        int      end_thr;
        res.stick_region = REGION_NONE;
        if (it.operation == OP_TICK) begin
            if (!ovr_active) begin
                low_thr = (it.throttle_level <= shadow_cfg.throttle_low_lvl);
                if (kill_pending) begin
                    // forced disarm wipes everything
                    is_armed = 1'b0;
                    kill_pending = 1'b0;
                    switch_released = 1'b0;
                    arm_ticks = '0;
                    disarm_ticks = '0;
                    idle_ticks = '0;
                end else if (!it.rc_connected || shadow_cfg.arm_direction == DIR_NONE) begin
                    is_armed = 1'b0;
                end else begin
                    // classify the stick or switch position
                    if (shadow_cfg.arm_direction == DIR_SWITCH) begin
                        res.stick_region = it.switch_top ? REGION_SWITCH : REGION_NONE;
                    end else if (low_thr) begin
                        case (shadow_cfg.arm_direction)
                            DIR_PITCH_MIN, DIR_PITCH_MAX: lvl = int'(it.pitch_level);
                            DIR_ROLL_MIN, DIR_ROLL_MAX:   lvl = int'(it.roll_level);
                            default:                      lvl = int'(it.yaw_level);
                        endcase
                        end_thr = 16384 - 2 * int'(shadow_cfg.throttle_low_lvl);
                        if (shadow_cfg.arm_direction[0]) begin
                            if (lvl <= -end_thr) res.stick_region = REGION_ARM;
                            else if (lvl >= end_thr) res.stick_region = REGION_DISARM;
                        end else begin
                            if (lvl >= end_thr) res.stick_region = REGION_ARM;
                            else if (lvl <= -end_thr) res.stick_region = REGION_DISARM;
                        end
                    end
                    if (is_armed && it.host_ctrl) idle_ticks = '0;
                    arm_due = (int'(arm_ticks) / TICKS_PER_SEC) * int'(ARM_SCALE)
                              >= int'(shadow_cfg.arm_hold_time);

                    // advance the arm and disarm counters
                    if (shadow_cfg.arm_direction == DIR_SWITCH) begin
                        if (res.stick_region == REGION_SWITCH) begin
                            if (!is_armed && switch_released && low_thr) begin
                                if (arm_due) begin
                                    is_armed = 1'b1;
                                    switch_released = 1'b0;
                                end else begin
                                    arm_ticks = bump(arm_ticks);
                                    idle_ticks = '0;
                                end
                            end else if (is_armed && switch_released) begin
                                switch_released = 1'b0;
                                is_armed = 1'b0;
                                arm_ticks = '0;
                                idle_ticks = '0;
                            end
                        end else begin
                            arm_ticks = '0;
                            idle_ticks = bump(idle_ticks);
                            switch_released = 1'b1;
                        end
                    end else if (res.stick_region == REGION_ARM) begin
                        if (arm_due) begin
                            is_armed = 1'b1;
                        end else begin
                            arm_ticks = bump(arm_ticks);
                            disarm_ticks = '0;
                            idle_ticks = '0;
                        end
                    end else if (res.stick_region == REGION_DISARM) begin
                        if (int'(disarm_ticks) / TICKS_PER_SEC
                                >= int'(shadow_cfg.arm_hold_time)) begin
                            is_armed = 1'b0;
                        end else begin
                            disarm_ticks = bump(disarm_ticks);
                            arm_ticks = '0;
                            idle_ticks = '0;
                        end
                    end else begin
                        arm_ticks = '0;
                        disarm_ticks = '0;
                    end

                    // zero-throttle timeout
                    if (shadow_cfg.zero_throttle_timeout != '0 && is_armed) begin
                        if (low_thr) begin
                            if (int'(idle_ticks) / TICKS_PER_SEC
                                    > int'(shadow_cfg.zero_throttle_timeout)) begin
                                is_armed = 1'b0;
                            end else begin
                                idle_ticks = bump(idle_ticks);
                                arm_ticks = '0;
                                disarm_ticks = '0;
                            end
                        end else begin
                            idle_ticks = '0;
                        end
                    end
                end
            end

            // override lapse
            if (kill_pending) ovr_active = 1'b0;
            else if (ovr_active && ovr_ticks > TICKS_PER_SEC / 2) ovr_active = 1'b0;
            else ovr_ticks = bump(ovr_ticks);
        end else if (it.operation == OP_DISARM) begin
            if (it.disarm_key == DISARM_KEY) kill_pending = 1'b1;
        end else if (it.operation == OP_OVERRIDE) begin
            if (it.override_length_ok) begin
                if (it.override_in_range) begin
                    ovr_ticks = '0;
                    ovr_active = 1'b1;
                end else begin
                    ovr_active = 1'b0;
                end
            end
        end
        res.armed = is_armed || ovr_active;
        res.override_on = ovr_active;
        return res;
    endfunction

    // Present queued items, idling at random between them
    always @(negedge i_clk) begin : drive_items
        if (rst_done && (!s_axis_tvalid || item_taken)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                driven_item = pending_items.pop_front();
                s_axis_tuser <= driven_item.operation;
                s_axis_tdata <= {4'b0000, driven_item.override_in_range,
                                 driven_item.override_length_ok, driven_item.disarm_key,
                                 driven_item.switch_top, driven_item.yaw_level,
                                 driven_item.roll_level, driven_item.pitch_level,
                                 driven_item.throttle_level, driven_item.host_ctrl,
                                 driven_item.rc_connected};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin : drive_ready
        m_axis_tready <= rst_done && ($urandom_range(99) >= stall_pct);
    end

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    // Check results against the oldest expectation, then predict accepted items
    always @(posedge i_clk) begin : watch_results
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.armed = m_axis_tdata[0];
                got.override_on = m_axis_tdata[1];
                got.stick_region = m_axis_tdata[3:2];
                if (expected_status.size() == 0) begin
                    flag_mismatch($sformatf("result 0x%02h with none pending", m_axis_tdata));
                end else begin
                    want = expected_status.pop_front();
                    if (got.armed !== want.armed)
                        flag_mismatch($sformatf("armed expected %0d, got %0d",
                                                want.armed, got.armed));
                    if (got.override_on !== want.override_on)
                        flag_mismatch($sformatf("override_on expected %0d, got %0d",
                                                want.override_on, got.override_on));
                    if (got.stick_region !== want.stick_region)
                        flag_mismatch($sformatf("stick_region expected %0d, got %0d",
                                                want.stick_region, got.stick_region));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_status.push_back(step_supervisor(driven_item));
                item_taken = 1'b1;
            end
        end
    end

    function automatic int level_any();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    function automatic t_item any_item();
        t_item it;
        it.operation = OP_TICK;
        it.rc_connected = 1'($urandom_range(1));
        it.host_ctrl = 1'($urandom_range(1));
        it.throttle_level = 15'($urandom_range(16384));
        it.pitch_level = 16'(level_any());
        it.roll_level = 16'(level_any());
        it.yaw_level = 16'(level_any());
        it.switch_top = 1'($urandom_range(1));
        it.disarm_key = $urandom;
        it.override_length_ok = 1'($urandom_range(1));
        it.override_in_range = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_item make_item(logic [1:0] op, bit rc, bit cc, int thr, int pitch,
                                        int roll, int yaw, bit sw, logic [31:0] key,
                                        bit len_ok, bit in_rng);
        t_item it;
        it.operation = op;
        it.rc_connected = rc;
        it.host_ctrl = cc;
        it.throttle_level = 15'(thr);
        it.pitch_level = 16'(pitch);
        it.roll_level = 16'(roll);
        it.yaw_level = 16'(yaw);
        it.switch_top = sw;
        it.disarm_key = key;
        it.override_length_ok = len_ok;
        it.override_in_range = in_rng;
        return it;
    endfunction

    // Tick with the armed axis placed in the aimed region (none means centered)
    function automatic t_item stick_tick(int aim);
        t_item it;
        int    end_thr;
        int    lo;
        int    m;
        it = any_item();
        it.rc_connected = ($urandom_range(39) != 0);
        it.host_ctrl = ($urandom_range(7) == 0);
        if ($urandom_range(9) == 0) it.throttle_level = 15'($urandom_range(16384));
        else it.throttle_level = 15'($urandom_range(int'(shadow_cfg.throttle_low_lvl)));
        end_thr = 16384 - 2 * int'(shadow_cfg.throttle_low_lvl);
        lo = (end_thr > 0) ? end_thr : 0;
        if (aim == REGION_NONE) begin
            m = (end_thr > 1) ? int'($urandom_range(2 * (end_thr - 1))) - (end_thr - 1) : 0;
        end else begin
            m = ($urandom_range(3) == 0) ? 16384 : int'($urandom_range(16384, lo));
            if (!((aim == REGION_ARM) ^ shadow_cfg.arm_direction[0])) m = -m;
        end
        case (shadow_cfg.arm_direction)
            DIR_ROLL_MIN, DIR_ROLL_MAX: it.roll_level = 16'(m);
            DIR_YAW_MIN, DIR_YAW_MAX:   it.yaw_level = 16'(m);
            default:                    it.pitch_level = 16'(m);
        endcase
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_THROTTLE_LOW:    shadow_cfg.throttle_low_lvl = val[14:0];
            CFG_ARM_DIRECTION:   shadow_cfg.arm_direction = val[2:0];
            CFG_ARM_HOLD_TIME:   shadow_cfg.arm_hold_time = val;
            default:             shadow_cfg.zero_throttle_timeout = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int thr, logic [2:0] dir, int hold, int zto);
        write_reg(CFG_THROTTLE_LOW, 16'(thr));
        write_reg(CFG_ARM_DIRECTION, 16'(dir));
        write_reg(CFG_ARM_HOLD_TIME, 16'(hold));
        write_reg(CFG_ZERO_THR_TIMEOUT, 16'(zto));
    endtask

    // Hold off until every queued item is out and every result is back
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed arm, disarm, idle and override sequences, some noise
    task automatic queue_sequences(int n);
        int    target;
        int    kind;
        int    len;
        int    aim;
        int    pick;
        t_item it;
        target = pending_items.size() + n;
        while (pending_items.size() < target) begin
            kind = $urandom_range(19);
            if (kind <= 5) begin
                pick = $urandom_range(5);
                aim = int'((pick <= 2) ? REGION_ARM : (pick <= 4) ? REGION_DISARM : REGION_NONE);
                len = $urandom_range(70, 1);
                repeat (len) pending_items.push_back(stick_tick(aim));
            end else if (kind <= 8) begin
                len = $urandom_range(60, 1);
                repeat (len) pending_items.push_back(stick_tick(REGION_NONE));
            end else if (kind <= 10) begin
                // tap the switch: released, then held
                len = $urandom_range(4, 1);
                repeat (len) begin
                    it = stick_tick(REGION_NONE);
                    it.switch_top = 1'b0;
                    pending_items.push_back(it);
                end
                len = $urandom_range(25, 1);
                repeat (len) begin
                    it = stick_tick(REGION_NONE);
                    it.switch_top = 1'b1;
                    pending_items.push_back(it);
                end
            end else if (kind <= 12) begin
                it = any_item();
                it.operation = OP_OVERRIDE;
                it.override_length_ok = ($urandom_range(9) != 0);
                it.override_in_range = ($urandom_range(4) != 0);
                pending_items.push_back(it);
                len = $urandom_range(14);
                repeat (len) pending_items.push_back(stick_tick($urandom_range(2)));
            end else if (kind <= 14) begin
                it = any_item();
                it.operation = OP_DISARM;
                pick = $urandom_range(9);
                if (pick <= 6) it.disarm_key = DISARM_KEY;
                else if (pick >= 8) it.disarm_key = DISARM_KEY ^ (32'd1 << $urandom_range(31));
                pending_items.push_back(it);
                len = $urandom_range(3);
                repeat (len) pending_items.push_back(stick_tick($urandom_range(2)));
            end else if (kind == 15) begin
                len = $urandom_range(5, 1);
                repeat (len) begin
                    it = stick_tick(REGION_ARM);
                    it.rc_connected = 1'b0;
                    pending_items.push_back(it);
                end
            end else if (kind == 16) begin
                len = $urandom_range(10, 1);
                repeat (len) begin
                    it = stick_tick($urandom_range(2));
                    if (shadow_cfg.throttle_low_lvl < 15'd16384)
                        it.throttle_level = 15'($urandom_range(16384,
                                            int'(shadow_cfg.throttle_low_lvl) + 1));
                    else
                        it.throttle_level = 15'd16384;
                    pending_items.push_back(it);
                end
            end else begin
                it = any_item();
                it.operation = 2'($urandom_range(3));
                pending_items.push_back(it);
            end
        end
    endtask

    task automatic run_phase(int thr, logic [2:0] dir, int hold, int zto,
                             int idle_pct, int stall, int n);
        wait_idle();
        configure(thr, dir, hold, zto);
        @(posedge i_clk);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        queue_sequences(n);
    endtask

    initial begin : run_test
        shadow_cfg.throttle_low_lvl = '0;
        shadow_cfg.arm_direction = DIR_NONE;
        shadow_cfg.arm_hold_time = HOLD_RESET;
        shadow_cfg.zero_throttle_timeout = TIMEOUT_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        // reset settings: no arm direction, override on and off
        pending_items.push_back(make_item(OP_TICK, 1, 1, 0, -16384, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_OVERRIDE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        pending_items.push_back(make_item(OP_OVERRIDE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        wait_idle();
        configure(2000, DIR_PITCH_MIN, 0, 1);
        @(posedge i_clk);

        // link down with every field at an extreme
        pending_items.push_back(make_item(OP_TICK, 0, 1, 16384, 16384, -16384, 16384, 1,
                                          32'hFFFF_FFFF, 1, 1));
        // arm, high throttle under computer control, disarm, arm again
        pending_items.push_back(make_item(OP_TICK, 1, 0, 0, -16384, 16384, -16384, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 1, 1, 16384, -16384, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 1, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 1, 0, 0, -16384, 0, 0, 0, 0, 0, 0));
        // wrong keys are ignored, the right one disarms on the next tick
        pending_items.push_back(make_item(OP_DISARM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_DISARM, 0, 0, 0, 0, 0, 0, 0,
                                          32'hFFFF_FFFF, 0, 0));
        pending_items.push_back(make_item(OP_DISARM, 0, 0, 0, 0, 0, 0, 0,
                                          DISARM_KEY ^ 32'd1, 0, 0));
        pending_items.push_back(make_item(OP_DISARM, 0, 0, 0, 0, 0, 0, 0, DISARM_KEY, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 1, 0, 0, -16384, 0, 0, 0, 0, 0, 0));
        // bad length ignored; forced disarm during override ends it and stays pending
        pending_items.push_back(make_item(OP_OVERRIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(OP_OVERRIDE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        pending_items.push_back(make_item(OP_DISARM, 0, 0, 0, 0, 0, 0, 0, DISARM_KEY, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 1, 0, 0, -16384, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 1, 0, 0, -16384, 0, 0, 0, 0, 0, 0));
        // unused operation code, then out-of-range override
        pending_items.push_back(make_item(OP_UNUSED, 1, 1, 16384, -1, -1, -1, 1,
                                          32'hFFFF_FFFF, 1, 1));
        pending_items.push_back(make_item(OP_OVERRIDE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));

        // random sequences over a spread of settings and idling patterns
        run_phase(1000, DIR_PITCH_MIN, 1, 1, 0, 0, 150);
        run_phase(0, DIR_PITCH_MAX, 0, 0, 71, 0, 150);
        run_phase(16384, DIR_ROLL_MIN, 2, 2, 0, 71, 150);
        run_phase(3000, DIR_ROLL_MAX, 1, 65535, 35, 35, 150);
        run_phase(500, DIR_YAW_MIN, 0, 1, 0, 0, 150);
        run_phase(8192, DIR_YAW_MAX, 3, 1, 71, 0, 150);
        run_phase(2000, DIR_SWITCH, 0, 1, 0, 71, 150);
        run_phase(4000, DIR_SWITCH, 1, 2, 35, 35, 150);
        run_phase(1500, DIR_NONE, 65535, 0, 0, 0, 150);
        run_phase($urandom_range(16384), 3'($urandom_range(7)), $urandom_range(3),
                  $urandom_range(3), 71, 0, 150);
        run_phase($urandom_range(16384), 3'($urandom_range(7)), $urandom_range(3),
                  $urandom_range(3), 35, 35, 150);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
